/* sv/svp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the sample voice player.
// Used by the controller, the datapath, the top level and the checker.
package svp_pkg;

    localparam int STORE_BYTES_DEF = 65536;
    localparam int FRAC_BITS       = 18;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [14:0] STEP_MIN = 15'd127;
    localparam logic [14:0] STEP_MAX = 15'd24576;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_KEY_ON  = 2'd1,
        OP_KEY_OFF = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FMT_PCM16  = 2'd0,
        FMT_PCM8   = 2'd1,
        FMT_ADPCM  = 2'd2,
        FMT_STREAM = 2'd3
    } t_fmt;

    localparam logic [2:0] CFG_FORMAT      = 3'd0;
    localparam logic [2:0] CFG_LOOP_MODE   = 3'd1;
    localparam logic [2:0] CFG_START_ADDR  = 3'd2;
    localparam logic [2:0] CFG_LOOP_START  = 3'd3;
    localparam logic [2:0] CFG_LOOP_END    = 3'd4;
    localparam logic [2:0] CFG_PITCH_FRAC  = 3'd5;
    localparam logic [2:0] CFG_OCTAVE      = 3'd6;
    localparam logic [2:0] CFG_TOTAL_LEVEL = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_SCALE,
        ST_STEP,
        ST_RD1,
        ST_RD2,
        ST_ADV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic store_wr;
        logic key_on;
        logic key_off;
        logic tick_start;
        logic mix;
        logic scale;
        logic rd_issue;
        logic rd_hi;
        logic cap_b0;
        logic cap_b1;
        logic advance;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic step_due;
        logic pcm16;
    } t_status;

    localparam logic [15:0] GAIN_BASE [16] = '{
        16'd32768, 16'd31378, 16'd30048, 16'd28774, 16'd27554, 16'd26386,
        16'd25267, 16'd24196, 16'd23170, 16'd22188, 16'd21247, 16'd20346,
        16'd19483, 16'd18657, 16'd17866, 16'd17109};

    localparam logic [3:0] NIBBLE_MULT [8] = '{
        4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13, 4'd15};

    localparam logic [9:0] STEP_RATE [8] = '{
        10'd230, 10'd230, 10'd230, 10'd230, 10'd307, 10'd409, 10'd512, 10'd614};

    function automatic logic [15:0] level_gain(input logic [7:0] tl);
        level_gain = GAIN_BASE[tl[3:0]] >> tl[7:4];
    endfunction

    // Phase increment with 18 fraction bits, octave shifted.
    function automatic logic [26:0] make_step(input logic [9:0] pf,
                                              input logic [3:0] oct);
        logic [26:0] s;
        s = {8'd0, 1'b1, pf, 8'd0};
        if (oct[3]) begin
            make_step = s >> (5'd16 - {1'b0, oct});
        end else begin
            make_step = s << oct[2:0];
        end
    endfunction

endpackage

/* sv/sample_voice_player_core.sv */
`timescale 1ns / 1ps
// Top level of the sample voice player: sequencer plus datapath.
// Depends on svp_pkg, svp_ctrl, svp_dp (and svp_ram below it).
//
// One wavetable voice. Store writes, key on and key off return nothing and leave
// the input side free for the next request. A tick decodes source samples one at
// a time from the single-port sample store (16-bit PCM reads two bytes per sample)
// and stalls the input side until it is done. A finished result sits in an
// output register, so the next request can be taken while it waits. The store
// depth STORE_BYTES must be a power of two; addresses wrap modulo the depth.
module sample_voice_player_core import svp_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_operation,
    input  logic [15:0]            i_mem_address,
    input  logic [7:0]             i_mem_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [15:0]     o_sample_out,
    output logic                   o_voice_active,
    output logic                   o_loop_passed,
    output logic [15:0]            o_position
);

    t_cmd    cmd;
    t_status status;

    svp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    svp_dp #(.STORE_BYTES(STORE_BYTES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_mem_address  (i_mem_address),
        .i_mem_byte     (i_mem_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_sample_out   (o_sample_out),
        .o_voice_active (o_voice_active),
        .o_loop_passed  (o_loop_passed),
        .o_position     (o_position)
    );

endmodule

/* sv/svp_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with one write or read per cycle and registered read.
// No dependencies.
module svp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/svp_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the sample voice player: request handshakes and datapath commands.
// Depends on svp_pkg.
module svp_ctrl import svp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic [1:0] i_operation,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (t_op'(i_operation))
                        OP_WRITE:   o_cmd.store_wr = 1'b1;
                        OP_KEY_ON:  o_cmd.key_on   = 1'b1;
                        OP_KEY_OFF: o_cmd.key_off  = 1'b1;
                        OP_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_state          = ST_MIX;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.step_due) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = ST_RD1;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RD1: begin
                o_cmd.cap_b0 = 1'b1;
                if (i_status.pcm16) begin
                    o_cmd.rd_issue = 1'b1;
                    o_cmd.rd_hi    = 1'b1;
                    n_state        = ST_RD2;
                end else begin
                    n_state = ST_ADV;
                end
            end
            ST_RD2: begin
                o_cmd.cap_b1 = 1'b1;
                n_state      = ST_ADV;
            end
            ST_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_STEP;
            end
            ST_DONE: begin
                // The result register frees up when its request is taken.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/svp_dp.sv */
`timescale 1ns / 1ps
// Datapath of the sample voice player: configuration, voice state, sample store,
// interpolation, level scaling and PCM/ADPCM decoding. Depends on svp_pkg, svp_ram.
module svp_dp import svp_pkg::*; #(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [15:0]            i_mem_address,
    input  logic [7:0]             i_mem_byte,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic signed [15:0]     o_sample_out,
    output logic                   o_voice_active,
    output logic                   o_loop_passed,
    output logic [15:0]            o_position
);

    localparam int AW = $clog2(STORE_BYTES);

    // Configuration.
    logic [1:0]  r_fmt;
    logic        r_loop_mode;
    logic [15:0] r_start, r_lstart, r_lend;
    logic [9:0]  r_pitch;
    logic [3:0]  r_oct;
    logic [7:0]  r_tl;

    // Voice state.
    logic               r_active, r_looped, r_tick_act;
    logic [15:0]        r_idx;
    logic [26:0]        r_frac, r_step;
    logic signed [15:0] r_prev, r_next, r_saved;
    logic [14:0]        r_prev_ss, r_next_ss, r_saved_ss;

    // Arithmetic pipeline and byte captures.
    logic signed [34:0] r_prod_a, r_prod_b;
    logic signed [15:0] r_interp, r_scaled;
    logic [7:0]         r_b0, r_b1;

    logic signed [15:0] r_out_sample;
    logic               r_out_active, r_out_loop;
    logic [15:0]        r_out_pos;

    // Store address.
    logic [16:0]    rd_off;
    logic [17:0]    rd_sum;
    logic [AW+17:0] rd_wide, wr_wide;
    logic [AW-1:0]  ram_addr;
    logic [7:0]     ram_rdata;

    always_comb begin
        case (t_fmt'(r_fmt))
            FMT_PCM16: rd_off = {r_idx, i_cmd.rd_hi};
            FMT_PCM8:  rd_off = {1'b0, r_idx};
            default:   rd_off = {2'b00, r_idx[15:1]};
        endcase
        rd_sum   = {2'b00, r_start} + {1'b0, rd_off};
        rd_wide  = (AW + 18)'(rd_sum);
        wr_wide  = (AW + 18)'(i_mem_address);
        ram_addr = i_cmd.store_wr ? wr_wide[AW-1:0] : rd_wide[AW-1:0];
    end

    svp_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store_wr),
        .i_addr  (ram_addr),
        .i_wdata (i_mem_byte),
        .o_rdata (ram_rdata)
    );

    // Interpolation operands.
    logic [17:0]        frac_lo;
    logic [18:0]        w_prev;
    logic signed [35:0] mix_sum;
    logic signed [32:0] scale_prod;

    always_comb begin
        frac_lo    = r_frac[FRAC_BITS-1:0];
        w_prev     = 19'(1 << FRAC_BITS) - {1'b0, frac_lo};
        mix_sum    = 36'(r_prod_a) + 36'(r_prod_b);
        scale_prod = r_interp * $signed({1'b0, level_gain(r_tl)});
    end

    // Decode of one source sample and loop handling.
    logic [3:0]         nib;
    logic [18:0]        mag_full;
    logic signed [17:0] adp_sum;
    logic [24:0]        ss_prod;
    logic [16:0]        ss_shift;
    logic signed [15:0] dec_sample;
    logic [14:0]        dec_ss;
    logic [15:0]        idx_inc;
    logic               at_lstart, hit_end;

    always_comb begin
        nib      = r_idx[0] ? r_b0[7:4] : r_b0[3:0];
        mag_full = 19'(NIBBLE_MULT[nib[2:0]]) * 19'(r_prev_ss);
        adp_sum  = nib[3] ? 18'(r_prev) - 18'(mag_full[18:3])
                          : 18'(r_prev) + 18'(mag_full[18:3]);
        ss_prod  = 25'(r_prev_ss) * 25'(STEP_RATE[nib[2:0]]);
        ss_shift = ss_prod[24:8];
        dec_ss   = r_next_ss;
        case (t_fmt'(r_fmt))
            FMT_PCM16: dec_sample = $signed({r_b1, r_b0});
            FMT_PCM8:  dec_sample = $signed({r_b0, 8'd0});
            default: begin
                if (adp_sum < -18'sd32768) begin
                    dec_sample = -16'sd32768;
                end else if (adp_sum > 18'sd32767) begin
                    dec_sample = 16'sd32767;
                end else begin
                    dec_sample = adp_sum[15:0];
                end
                if (ss_shift < 17'(STEP_MIN)) begin
                    dec_ss = STEP_MIN;
                end else if (ss_shift > 17'(STEP_MAX)) begin
                    dec_ss = STEP_MAX;
                end else begin
                    dec_ss = ss_shift[14:0];
                end
            end
        endcase
        idx_inc   = r_idx + 16'd1;
        at_lstart = (r_idx == r_lstart);
        hit_end   = (idx_inc >= r_lend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= '0;
            r_loop_mode <= 1'b0;
            r_start     <= '0;
            r_lstart    <= '0;
            r_lend      <= '0;
            r_pitch     <= '0;
            r_oct       <= '0;
            r_tl        <= '0;
            r_active    <= 1'b0;
            r_looped    <= 1'b0;
            r_tick_act  <= 1'b0;
            r_idx       <= '0;
            r_frac      <= '0;
            r_step      <= '0;
            r_prev      <= '0;
            r_next      <= '0;
            r_saved     <= '0;
            r_prev_ss   <= STEP_MIN;
            r_next_ss   <= STEP_MIN;
            r_saved_ss  <= STEP_MIN;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FORMAT:      r_fmt       <= i_cfg_data[1:0];
                    CFG_LOOP_MODE:   r_loop_mode <= i_cfg_data[0];
                    CFG_START_ADDR:  r_start     <= i_cfg_data;
                    CFG_LOOP_START:  r_lstart    <= i_cfg_data;
                    CFG_LOOP_END:    r_lend      <= i_cfg_data;
                    CFG_PITCH_FRAC: begin
                        r_pitch <= i_cfg_data[9:0];
                        r_step  <= make_step(i_cfg_data[9:0], r_oct);
                    end
                    CFG_OCTAVE: begin
                        r_oct  <= i_cfg_data[3:0];
                        r_step <= make_step(r_pitch, i_cfg_data[3:0]);
                    end
                    CFG_TOTAL_LEVEL: r_tl <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.key_on && !r_active) begin
                r_active   <= 1'b1;
                r_idx      <= '0;
                r_frac     <= '0;
                r_step     <= make_step(r_pitch, r_oct);
                r_looped   <= 1'b0;
                r_prev     <= '0;
                r_next     <= '0;
                r_saved    <= '0;
                r_prev_ss  <= STEP_MIN;
                r_next_ss  <= STEP_MIN;
                r_saved_ss <= STEP_MIN;
            end
            if (i_cmd.key_off) begin
                r_active <= 1'b0;
            end
            if (i_cmd.tick_start) begin
                r_tick_act <= r_active;
            end
            if (i_cmd.scale && r_active) begin
                r_frac <= r_frac + r_step;
            end
            if (i_cmd.advance) begin
                if (at_lstart) begin
                    r_saved    <= r_prev;
                    r_saved_ss <= r_prev_ss;
                end
                r_next    <= dec_sample;
                r_next_ss <= dec_ss;
                r_prev    <= dec_sample;
                r_prev_ss <= dec_ss;
                r_frac    <= r_frac - 27'(1 << FRAC_BITS);
                r_idx     <= idx_inc;
                if (hit_end) begin
                    r_looped <= 1'b1;
                    if (!r_loop_mode) begin
                        r_active <= 1'b0;
                    end else begin
                        r_idx <= r_lstart;
                        // Saving and restoring in the same step hands back the old value.
                        if (t_fmt'(r_fmt) != FMT_STREAM) begin
                            r_prev    <= at_lstart ? r_prev : r_saved;
                            r_prev_ss <= at_lstart ? r_prev_ss : r_saved_ss;
                        end
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_looped <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_prod_a <= r_prev * $signed({1'b0, w_prev});
            r_prod_b <= r_next * $signed({1'b0, frac_lo});
        end
        if (i_cmd.mix) begin
            r_interp <= 16'(mix_sum >>> FRAC_BITS);
        end
        if (i_cmd.scale) begin
            r_scaled <= 16'(scale_prod >>> 15);
        end
        if (i_cmd.cap_b0) begin
            r_b0 <= ram_rdata;
        end
        if (i_cmd.cap_b1) begin
            r_b1 <= ram_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_sample <= r_tick_act ? r_scaled : 16'sd0;
            r_out_active <= r_active;
            r_out_loop   <= r_looped;
            r_out_pos    <= r_idx;
        end
    end

    assign o_status.step_due = r_active && (r_frac[26:FRAC_BITS] != '0);
    assign o_status.pcm16    = (t_fmt'(r_fmt) == FMT_PCM16);
    assign o_sample_out      = r_out_sample;
    assign o_voice_active    = r_out_active;
    assign o_loop_passed     = r_out_loop;
    assign o_position        = r_out_pos;

endmodule

/* sv/svp_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the sample voice player, bound to the top level.
// Depends on svp_pkg and sample_voice_player_core.
module svp_checker import svp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_we,
    input logic [CFG_INDEX_W-1:0] i_cfg_index,
    input logic [CFG_DATA_W-1:0]  i_cfg_data,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic [1:0]             i_operation,
    input logic [15:0]            i_mem_address,
    input logic [7:0]             i_mem_byte,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic signed [15:0]     o_sample_out,
    input logic                   o_voice_active,
    input logic                   o_loop_passed,
    input logic [15:0]            o_position
);

    // A request that is not a tick finishes in its own cycle.
    a_short_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_operation != OP_TICK) |=> !o_in_stall)
        else $error("input side stalled after a non-tick request");

    // A tick keeps the input side busy while it works.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_operation == OP_TICK) |=> o_in_stall)
        else $error("input side free right after a tick request");

    // A result cannot appear without a tick having occupied the input side.
    a_result_needs_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a tick in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out)
            && $stable(o_position)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear the handshake");

endmodule

bind sample_voice_player_core svp_checker u_svp_checker (.*);
